// ----- rtl/qvr_pkg.sv -----
// Shared types, constants and rounding helper for the quaternion vector rotator.
package qvr_pkg;

  // Fraction bits of the quaternion components (Q2.30).
  localparam int unsigned QF = 30;
  // Width of the vector and quaternion fields.
  localparam int unsigned VW = 32;
  // Width of c = q0^2 - |u|^2 after rounding.
  localparam int unsigned CW = 35;
  // Width of the modulus.
  localparam int unsigned MW = 32;
  // Width of the unnormalized coordinate N.
  localparam int unsigned NW = 40;
  // Width of a raw product before rounding.
  localparam int unsigned PW = 68;
  // Width of the divider's dividend.
  localparam int unsigned DW = NW - 1 + QF - 1 + 1;
  // Divider stages, two quotient bits each.
  localparam int unsigned DIV_STAGES = 16;

  localparam logic [VW-1:0] QS_RESET = VW'(1) << QF;

  // Register map, word index.
  typedef enum logic [1:0] {
    REG_QS,
    REG_QI,
    REG_QJ,
    REG_QK
  } reg_idx_t;

  // Sequencer for the quaternion-only terms.
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SQUARE,
    SQ_ROOT
  } seq_state_t;

  // Quaternion and derived terms handed to the datapath.
  typedef struct packed {
    logic signed [VW-1:0] q0;
    logic signed [VW-1:0] qi;
    logic signed [VW-1:0] qj;
    logic signed [VW-1:0] qk;
    logic signed [CW-1:0] c;
    logic [MW-1:0]        m;
    logic                 busy;
  } coef_t;

  // Shift right by sh with rounding to nearest, ties away from zero.
  function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] p,
                                                     input int unsigned sh);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    r = (mag + (PW'(1) << (sh - 1))) >> sh;
    return p[PW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

// ----- rtl/qvr_coef.sv -----
// Configuration registers and the sequencer that derives c and the modulus.
module qvr_coef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output qvr_pkg::coef_t     coef
);
  import qvr_pkg::*;

  logic signed [VW-1:0] q0_r, qi_r, qj_r, qk_r;
  seq_state_t           state_r, state_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [62:0]          prod_r;
  logic [63:0]          s_acc_r;
  logic signed [CW-1:0] c_acc_r;
  logic [63:0]          root_n_r, res_r, bit_r;
  logic                 wr;
  reg_idx_t             idx;
  logic signed [VW-1:0] sel;
  logic [PW-1:0]        sq_rnd;
  logic [63:0]          trial;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r <= QS_RESET;
      qi_r <= '0;
      qj_r <= '0;
      qk_r <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_QS: q0_r <= pwdata;
        REG_QI: qi_r <= pwdata;
        REG_QJ: qj_r <= pwdata;
        REG_QK: qk_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (idx)
      REG_QS: prdata = q0_r;
      REG_QI: prdata = qi_r;
      REG_QJ: prdata = qj_r;
      REG_QK: prdata = qk_r;
      default: prdata = '0;
    endcase
  end

  // Next state: any write restarts the derivation.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    unique case (state_r)
      SQ_IDLE: cnt_nxt = '0;
      SQ_SQUARE: begin
        if (cnt_r == 5'd4) begin
          state_nxt = SQ_ROOT;
          cnt_nxt   = '0;
        end
      end
      SQ_ROOT: begin
        if (cnt_r == 5'd31) begin
          state_nxt = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
    if (wr) begin
      state_nxt = SQ_SQUARE;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_SQUARE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Component selected for squaring in this cycle.
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    sel = q0_r;
      3'd1:    sel = qi_r;
      3'd2:    sel = qj_r;
      3'd3:    sel = qk_r;
      default: sel = '0;
    endcase
  end

  assign sq_rnd = rnd_shift($signed(PW'(prod_r)), QF);
  assign trial  = res_r + bit_r;

  // Squares, sums and the digit-by-digit square root.
  always_ff @(posedge clk) begin
    if (state_r == SQ_SQUARE) begin
      prod_r <= 63'(64'(sel) * 64'(sel));
      if (cnt_r == 5'd0) begin
        s_acc_r <= '0;
        c_acc_r <= '0;
      end else begin
        s_acc_r <= s_acc_r + 64'(prod_r >> 2);
        if (cnt_r == 5'd1) begin
          c_acc_r <= c_acc_r + CW'(sq_rnd);
        end else begin
          c_acc_r <= c_acc_r - CW'(sq_rnd);
        end
      end
      if (cnt_r == 5'd4) begin
        root_n_r <= s_acc_r + 64'(prod_r >> 2);
        res_r    <= '0;
        bit_r    <= 64'(1) << 62;
      end
    end else if (state_r == SQ_ROOT) begin
      if (root_n_r >= trial) begin
        root_n_r <= root_n_r - trial;
        res_r    <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    coef.q0   = q0_r;
    coef.qi   = qi_r;
    coef.qj   = qj_r;
    coef.qk   = qk_r;
    coef.c    = c_acc_r;
    coef.m    = res_r[MW-1:0];
    coef.busy = (state_r != SQ_IDLE);
  end

endmodule

// ----- rtl/qvr_arith.sv -----
// Four-stage datapath forming the unnormalized rotated coordinates.
module qvr_arith (
  input  logic                        clk,
  input  logic                        en,
  input  qvr_pkg::coef_t              coef,
  input  logic signed [31:0]          vec_x,
  input  logic signed [31:0]          vec_y,
  input  logic signed [31:0]          vec_z,
  input  logic                        kind,
  output logic signed [qvr_pkg::NW-1:0] n_o [3]
);
  import qvr_pkg::*;

  logic signed [VW-1:0] u [3];
  logic signed [VW-1:0] v [3];
  logic signed [PW-1:0] p1_r [3][3];
  logic signed [VW-1:0] v1_r [3], v2_r [3];
  logic                 k1_r, k2_r, k3_r;
  logic signed [PW-1:0] r2 [3][3];
  logic signed [CW-1:0] d_r;
  logic signed [CW-1:0] w_r [3];
  logic signed [PW-1:0] cv_r [3], du_r [3], qw_r [3];
  logic signed [NW-1:0] n_r [3];

  assign u[0] = coef.qi;
  assign u[1] = coef.qj;
  assign u[2] = coef.qk;
  assign v[0] = vec_x;
  assign v[1] = vec_y;
  assign v[2] = vec_z;

  // Stage 1: all nine products of u and v.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1_r[i][j] <= PW'(u[i]) * PW'(v[j]);
        end
        v1_r[i] <= v[i];
      end
      k1_r <= kind;
    end
  end

  // Stage 2: rounding, dot product and cross product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r2[i][j] = rnd_shift(p1_r[i][j], QF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= CW'(r2[0][0] + r2[1][1] + r2[2][2]);
      w_r[0] <= CW'(r2[1][2] - r2[2][1]);
      w_r[1] <= CW'(r2[2][0] - r2[0][2]);
      w_r[2] <= CW'(r2[0][1] - r2[1][0]);
      v2_r   <= v1_r;
      k2_r   <= k1_r;
    end
  end

  // Stage 3: scale by c, d and q0.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cv_r[i] <= PW'(coef.c) * PW'(v2_r[i]);
        du_r[i] <= PW'(d_r) * PW'(u[i]);
        qw_r[i] <= PW'(coef.q0) * PW'(w_r[i]);
      end
      k3_r <= k2_r;
    end
  end

  // Stage 4: round and sum; the cross term flips sign for the inverse.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (k3_r) begin
          n_r[i] <= NW'(rnd_shift(cv_r[i], QF) + rnd_shift(du_r[i], QF - 1)
                        - rnd_shift(qw_r[i], QF - 1));
        end else begin
          n_r[i] <= NW'(rnd_shift(cv_r[i], QF) + rnd_shift(du_r[i], QF - 1)
                        + rnd_shift(qw_r[i], QF - 1));
        end
      end
    end
  end

  assign n_o = n_r;

endmodule

// ----- rtl/qvr_norm.sv -----
// Pipelined divide by the modulus and saturation for one coordinate.
module qvr_norm (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qvr_pkg::NW-1:0] n_i,
  input  logic [qvr_pkg::MW-1:0]        m_i,
  output logic signed [31:0]            rot_o,
  output logic                          clip_o
);
  import qvr_pkg::*;

  localparam logic signed [NW-1:0] N_MAX = NW'(32'h7fffffff);
  localparam logic signed [NW-1:0] N_MIN = -N_MAX - NW'(1);

  logic [NW-1:0]        mag;
  logic [DW-1:0]        dvd;
  logic [MW-1:0]        rem_r [DIV_STAGES+1];
  logic [31:0]          ql_r  [DIV_STAGES+1];
  logic                 neg_r [DIV_STAGES+1];
  logic                 ovf_r [DIV_STAGES+1];
  logic                 mz_r  [DIV_STAGES+1];
  logic signed [NW-1:0] n_r   [DIV_STAGES+1];
  logic [MW-1:0]        rem_nxt [DIV_STAGES];
  logic [31:0]          ql_nxt  [DIV_STAGES];
  logic [MW:0]          cur;
  logic [31:0]          q;
  logic signed [31:0]   rot_r;
  logic                 clip_r;

  // Dividend: |N| shifted up, plus half the modulus for rounding.
  assign mag = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
  assign dvd = DW'({mag[NW-2:0], (QF - 1)'(0)}) + DW'(m_i >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= MW'(dvd[DW-1:32]);
      ql_r[0]  <= dvd[31:0];
      neg_r[0] <= n_i[NW-1];
      ovf_r[0] <= dvd >= DW'({m_i, 32'b0});
      mz_r[0]  <= (m_i == '0);
      n_r[0]   <= n_i;
    end
  end

  // Restoring division, two quotient bits per stage.
  always_comb begin
    cur = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_nxt[k] = rem_r[k];
      ql_nxt[k]  = ql_r[k];
      for (int j = 0; j < 2; j++) begin
        cur = {rem_nxt[k], ql_nxt[k][31]};
        if (cur >= {1'b0, m_i}) begin
          rem_nxt[k] = MW'(cur - {1'b0, m_i});
          ql_nxt[k]  = {ql_nxt[k][30:0], 1'b1};
        end else begin
          rem_nxt[k] = MW'(cur);
          ql_nxt[k]  = {ql_nxt[k][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        ql_r[k+1]  <= ql_nxt[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        mz_r[k+1]  <= mz_r[k];
        n_r[k+1]   <= n_r[k];
      end
    end
  end

  assign q = ql_r[DIV_STAGES];

  // Sign restore and clamp to the output range; a zero modulus passes N through unscaled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (mz_r[DIV_STAGES]) begin
        if (n_r[DIV_STAGES] > N_MAX) begin
          rot_r  <= 32'sh7fffffff;
          clip_r <= 1'b1;
        end else if (n_r[DIV_STAGES] < N_MIN) begin
          rot_r  <= 32'sh80000000;
          clip_r <= 1'b1;
        end else begin
          rot_r  <= n_r[DIV_STAGES][31:0];
          clip_r <= 1'b0;
        end
      end else if (!neg_r[DIV_STAGES]) begin
        if (ovf_r[DIV_STAGES] || q[31]) begin
          rot_r  <= 32'sh7fffffff;
          clip_r <= 1'b1;
        end else begin
          rot_r  <= q;
          clip_r <= 1'b0;
        end
      end else begin
        if (ovf_r[DIV_STAGES] || q > 32'h80000000) begin
          rot_r  <= 32'sh80000000;
          clip_r <= 1'b1;
        end else begin
          rot_r  <= -q;
          clip_r <= 1'b0;
        end
      end
    end
  end

  assign rot_o  = rot_r;
  assign clip_o = clip_r;

endmodule

// ----- rtl/quaternion_vector_rotator_unit.sv -----
// Request acceptance to result valid: 4 arithmetic stages, 1 dividend stage,
// 16 divider stages of two bits each, 1 output stage. Throughput: one request per cycle
// while coef.busy is low; the whole pipeline advances when the output is free.
// Reset (synchronous, rst_n low) loads the identity quaternion and empties the pipeline.
// After reset or any register write, c and the modulus are derived anew
// (squaring and a 32-step square root); in_ready stays low meanwhile.
module quaternion_vector_rotator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic               in_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic               out_clipped
);
  import qvr_pkg::*;

  localparam int unsigned LAT = 4 + 1 + DIV_STAGES + 1;

  coef_t                coef;
  logic                 en;
  logic [LAT-1:0]       vld_r;
  logic signed [NW-1:0] n [3];
  logic                 clip [3];

  qvr_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // The pipeline moves whenever the output register is empty or being taken.
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en && !coef.busy;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid && in_ready};
    end
  end

  qvr_arith u_arith (
    .clk   (clk),
    .en    (en),
    .coef  (coef),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .kind  (in_kind),
    .n_o   (n)
  );

  qvr_norm u_norm_x (
    .clk (clk), .en (en), .n_i (n[0]), .m_i (coef.m), .rot_o (out_rot_x), .clip_o (clip[0])
  );
  qvr_norm u_norm_y (
    .clk (clk), .en (en), .n_i (n[1]), .m_i (coef.m), .rot_o (out_rot_y), .clip_o (clip[1])
  );
  qvr_norm u_norm_z (
    .clk (clk), .en (en), .n_i (n[2]), .m_i (coef.m), .rot_o (out_rot_z), .clip_o (clip[2])
  );

  assign out_valid   = vld_r[LAT-1];
  assign out_clipped = clip[0] || clip[1] || clip[2];

`ifndef NO_ASSERTIONS
  // No request enters while the derived terms are being recomputed.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    coef.busy |-> !(in_valid && in_ready))
    else $error("request accepted while coefficients are busy");

  // A clipped result carries a saturated coordinate.
  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_rot_x == 32'sh7fffffff || out_rot_x == 32'sh80000000 ||
       out_rot_y == 32'sh7fffffff || out_rot_y == 32'sh80000000 ||
       out_rot_z == 32'sh7fffffff || out_rot_z == 32'sh80000000))
    else $error("clipped flag without a saturated coordinate");

  // A stalled output keeps the whole pipeline frozen.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved during an output stall");
`endif

endmodule

// ----- verif/qvr_rotation_checker.sv -----
// Checker for the quaternion vector rotator: bit-exact rotation predictor and result compare.
`timescale 1ns / 100ps

module qvr_rotation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic               in_kind,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_rot_x,
  input  logic signed [31:0] out_rot_y,
  input  logic signed [31:0] out_rot_z,
  input  logic               out_clipped,
  output int                 fail_count,
  output int                 pending_count
);
  import qvr_pkg::*;

  typedef logic signed [63:0] s64_t;

  localparam s64_t S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clipped;
  } rotated_vec_t;

  // Model copy of the quaternion registers.
  logic signed [31:0] quat[4];
  rotated_vec_t       rotations_due[$];

  function automatic s64_t sat_add(s64_t a, s64_t b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t > 65'(S64_MAX)) return S64_MAX;
    if (t < 65'(S64_MIN)) return S64_MIN;
    return t[63:0];
  endfunction

  function automatic s64_t sat_neg(s64_t a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic [63:0] mag64(s64_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  // Exact product scaled by 2^-sh, rounded to nearest with ties away from zero.
  function automatic s64_t mul_round(s64_t a, s64_t b, int unsigned sh);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    m = (p > 128'(S64_MAX)) ? 64'(S64_MAX) : p[63:0];
    return (a[63] != b[63]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Divide by the modulus; a zero modulus leaves the value alone.
  function automatic s64_t scale_by_modulus(s64_t n, logic [63:0] m);
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  r;
    if (m == 0) return n;
    num = ({64'd0, mag64(n)} << (QF - 1)) + {64'd0, m >> 1};
    quo = num / {64'd0, m};
    r = (quo > 128'(S64_MAX)) ? 64'(S64_MAX) : quo[63:0];
    return n[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic rotated_vec_t rotate_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                                                 logic signed [31:0] vz, logic inverse);
    s64_t         q0;
    s64_t         u[3];
    s64_t         v[3];
    s64_t         w[3];
    s64_t         c;
    s64_t         d;
    s64_t         su;
    s64_t         t3;
    s64_t         n;
    s64_t         r;
    logic [63:0]  sq;
    logic [63:0]  m;
    rotated_vec_t res;
    logic signed [31:0] outv[3];
    q0 = quat[REG_QS];
    u[0] = quat[REG_QI];
    u[1] = quat[REG_QJ];
    u[2] = quat[REG_QK];
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    res.clipped = 1'b0;

    // Modulus in units of 2^-(QF-1).
    sq = ((mag64(q0) * mag64(q0)) >> 2) + ((mag64(u[0]) * mag64(u[0])) >> 2)
       + ((mag64(u[1]) * mag64(u[1])) >> 2) + ((mag64(u[2]) * mag64(u[2])) >> 2);
    m = int_sqrt(sq);

    su = sat_add(sat_add(mul_round(u[0], u[0], QF), mul_round(u[1], u[1], QF)),
                 mul_round(u[2], u[2], QF));
    c = sat_add(mul_round(q0, q0, QF), sat_neg(su));
    d = sat_add(sat_add(mul_round(u[0], v[0], QF), mul_round(u[1], v[1], QF)),
                mul_round(u[2], v[2], QF));
    w[0] = sat_add(mul_round(u[1], v[2], QF), sat_neg(mul_round(u[2], v[1], QF)));
    w[1] = sat_add(mul_round(u[2], v[0], QF), sat_neg(mul_round(u[0], v[2], QF)));
    w[2] = sat_add(mul_round(u[0], v[1], QF), sat_neg(mul_round(u[1], v[0], QF)));

    // Closed form per coordinate, then normalize and clamp to 32 bits.
    for (int i = 0; i < 3; i++) begin
      t3 = mul_round(q0, w[i], QF - 1);
      n = sat_add(mul_round(c, v[i], QF), mul_round(d, u[i], QF - 1));
      n = sat_add(n, inverse ? sat_neg(t3) : t3);
      r = scale_by_modulus(n, m);
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        res.clipped = 1'b1;
      end
      if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        res.clipped = 1'b1;
      end
      outv[i] = r[31:0];
    end
    res.x = outv[0];
    res.y = outv[1];
    res.z = outv[2];
    return res;
  endfunction

  assign pending_count = rotations_due.size();

  // Track requests, register writes and results at each rising edge.
  always @(posedge clk) begin
    rotated_vec_t want;
    if (!rst_n) begin
      quat[REG_QS] <= QS_RESET;
      quat[REG_QI] <= '0;
      quat[REG_QJ] <= '0;
      quat[REG_QK] <= '0;
      rotations_due.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        rotations_due.push_back(rotate_vector(in_vec_x, in_vec_y, in_vec_z, in_kind));
      if (psel && penable && pwrite && pready)
        quat[reg_idx_t'(paddr[3:2])] <= pwdata;
      if (out_valid && out_ready) begin
        if (rotations_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result %h %h %h %b", $realtime,
                     out_rot_x, out_rot_y, out_rot_z, out_clipped);
          fail_count <= fail_count + 1;
        end else begin
          want = rotations_due.pop_front();
          if (want.x !== out_rot_x || want.y !== out_rot_y || want.z !== out_rot_z ||
              want.clipped !== out_clipped) begin
            if (fail_count < 10)
              $display("%0t: expected %h %h %h %b, got %h %h %h %b", $realtime,
                       want.x, want.y, want.z, want.clipped,
                       out_rot_x, out_rot_y, out_rot_z, out_clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/tb_quaternion_vector_rotator_unit.sv -----
// Testbench top for the quaternion vector rotator: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb_quaternion_vector_rotator_unit;
  import qvr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PER_PHASE = 160;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_vec_x;
  logic signed [31:0] in_vec_y;
  logic signed [31:0] in_vec_z;
  logic               in_kind;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_rot_x;
  logic signed [31:0] out_rot_y;
  logic signed [31:0] out_rot_z;
  logic               out_clipped;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count;

  quaternion_vector_rotator_unit dut (.*);

  qvr_rotation_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls in one of four modes, taken in turn as the cycle count advances.
  always @(negedge clk) begin
    int mode;
    mode = (cycle_count / 64) % 4;
    case (mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= ($urandom_range(0, 9) < 3);
      default: out_ready <= cycle_count[3];
    endcase
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_quat(logic [31:0] q0, logic [31:0] qi, logic [31:0] qj, logic [31:0] qk);
    write_reg(REG_QS, q0);
    write_reg(REG_QI, qi);
    write_reg(REG_QJ, qj);
    write_reg(REG_QK, qk);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_request(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic k);
    @(negedge clk);
    in_valid = 1'b1;
    in_vec_x = x;
    in_vec_y = y;
    in_vec_z = z;
    in_kind = k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8'hff)) - 128);
      default: return 32'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
    endcase
  endfunction

  // Random requests sent in bursts with random gaps; one pause until drained.
  task automatic random_phase(int count);
    int burst;
    int drain_at;
    drain_at = $urandom_range(10, count - 10);
    for (int i = 0; i < count; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && i < count; b++, i++) begin
        send_request(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
        if (i == drain_at) begin
          idle_cycles(1);
          wait_drained();
        end
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
    idle_cycles(1);
    wait_drained();
  endtask

  function automatic logic [31:0] rand_quat_part();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000);
      2: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  initial begin
    logic [31:0] dir_vec[12][3];
    cycle_count = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_kind = 1'b0;
    out_ready = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_vec = '{'{0, 0, 0}, '{32'h0001_0000, 0, 0}, '{0, 32'h0001_0000, 0},
                '{0, 0, 32'h0001_0000}, '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001},
                '{32'hffff_ffff, 32'h0000_0001, 32'hffff_0000},
                '{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678},
                '{32'h8000_0000, 32'h7fff_ffff, 0}, '{32'h0000_ffff, 32'hffff_8000, 32'h0100_0000},
                '{32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987}};

    // Directed: reset identity, then a 90 degree turn about z, both directions.
    for (int i = 0; i < 12; i++)
      send_request(dir_vec[i][0], dir_vec[i][1], dir_vec[i][2], i[0]);
    idle_cycles(1);
    wait_drained();
    repeat (24) @(posedge clk);
    set_quat(32'd759250125, 32'd0, 32'd0, 32'd759250125);
    for (int i = 0; i < 12; i++)
      send_request(dir_vec[i][0], dir_vec[i][1], dir_vec[i][2], ~i[0]);
    idle_cycles(1);
    wait_drained();
    random_phase(RAND_PER_PHASE);

    // Register extremes: all maximum, all minimum, zero, tiny (modulus rounds to zero).
    set_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    random_phase(RAND_PER_PHASE);
    set_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_phase(RAND_PER_PHASE);
    set_quat(32'h0, 32'h0, 32'h0, 32'h0);
    random_phase(60);
    set_quat(32'h1, 32'hffff_ffff, 32'h0, 32'h1);
    random_phase(60);

    // Random quaternions.
    for (int p = 0; p < 5; p++) begin
      repeat (24) @(posedge clk);
      set_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
      random_phase(RAND_PER_PHASE);
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
